// ----- rtl/lkvt_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvt_pkg
// Shared types, field widths and the microcode program of the key-value table.
// ----------------------------------------------------------------------------
package lkvt_pkg;

    localparam int OP_W    = 3;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 6;
    localparam int TDATA_W = 72;

    localparam int DEPTH_DEF       = 32;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 3'd0,
        OP_APPEND = 3'd1,
        OP_GET    = 3'd2,
        OP_DELETE = 3'd3,
        OP_READ   = 3'd4
    } t_lkvt_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BEYOND    = 2'd3
    } t_lkvt_status;

    typedef enum logic [4:0] {
        S_IDLE        = 5'd0,
        S_DISP        = 5'd1,
        S_SEARCH      = 5'd2,
        S_FOUNDQ      = 5'd3,
        S_HIT         = 5'd4,
        S_MISS        = 5'd5,
        S_PUT_UPD     = 5'd6,
        S_DEL_PREP    = 5'd7,
        S_DEL_SHIFT   = 5'd8,
        S_DEL_DONE    = 5'd9,
        S_RDPOS       = 5'd10,
        S_EMIT_RD     = 5'd11,
        S_APP         = 5'd12,
        S_EMIT_OK     = 5'd13,
        S_EMIT_GETV   = 5'd14,
        S_EMIT_NF     = 5'd15,
        S_EMIT_FULL   = 5'd16,
        S_EMIT_BEYOND = 5'd17
    } t_lkvt_step;

    typedef enum logic [3:0] {
        C_NEXT      = 4'd0,
        C_ALWAYS    = 4'd1,
        C_ACCEPT    = 4'd2,
        C_DISP_OP   = 4'd3,
        C_DISP_HIT  = 4'd4,
        C_DISP_MISS = 4'd5,
        C_DONE      = 4'd6,
        C_END       = 4'd7,
        C_LAST      = 4'd8,
        C_FULL      = 4'd9,
        C_POS_BAD   = 4'd10,
        C_OUT_FREE  = 4'd11
    } t_lkvt_cond;

    typedef enum logic [1:0] {
        IDX_KEEP = 2'd0,
        IDX_ZERO = 2'd1,
        IDX_INC  = 2'd2,
        IDX_POS  = 2'd3
    } t_lkvt_idx_op;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_IDX   = 2'd1,
        WR_CNT   = 2'd2,
        WR_SHIFT = 2'd3
    } t_lkvt_wr_op;

    typedef enum logic [1:0] {
        CNT_KEEP = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } t_lkvt_cnt_op;

    typedef struct packed {
        t_lkvt_cond   cond;
        t_lkvt_step   target;
        logic         hold;
        logic         nt_only;
        logic         accept;
        t_lkvt_idx_op idx_op;
        logic         rd_ahead;
        t_lkvt_wr_op  wr_op;
        t_lkvt_cnt_op cnt_op;
        logic         emit;
        t_lkvt_status status;
        logic         kout_rd;
        logic         vout_rd;
    } t_lkvt_ctrl;

    typedef struct packed {
        logic         ready;
        logic         load_in;
        t_lkvt_idx_op idx_op;
        logic         rd_ahead;
        t_lkvt_wr_op  wr_op;
        t_lkvt_cnt_op cnt_op;
        logic         emit;
        t_lkvt_status status;
        logic         kout_rd;
        logic         vout_rd;
    } t_lkvt_act;

    typedef struct packed {
        logic            in_valid;
        logic            out_free;
        logic            at_end;
        logic            match;
        logic            last;
        logic            full;
        logic            pos_bad;
        logic [OP_W-1:0] op;
    } t_lkvt_flags;

    localparam t_lkvt_ctrl UC_NOP = '{
        cond: C_NEXT, target: S_IDLE, hold: 1'b0, nt_only: 1'b0, accept: 1'b0,
        idx_op: IDX_KEEP, rd_ahead: 1'b0, wr_op: WR_NONE, cnt_op: CNT_KEEP,
        emit: 1'b0, status: ST_OK, kout_rd: 1'b0, vout_rd: 1'b0
    };

    function automatic t_lkvt_ctrl lkvt_rom(input t_lkvt_step step);
        t_lkvt_ctrl w;
        w = UC_NOP;
        unique case (step)
            S_IDLE: begin
                w.cond   = C_ACCEPT;
                w.target = S_DISP;
                w.hold   = 1'b1;
                w.accept = 1'b1;
                w.idx_op = IDX_ZERO;
            end
            S_DISP: begin
                w.cond = C_DISP_OP;
            end
            S_SEARCH: begin
                w.cond    = C_DONE;
                w.target  = S_FOUNDQ;
                w.hold    = 1'b1;
                w.nt_only = 1'b1;
                w.idx_op  = IDX_INC;
            end
            S_FOUNDQ: begin
                w.cond   = C_END;
                w.target = S_MISS;
            end
            S_HIT: begin
                w.cond = C_DISP_HIT;
            end
            S_MISS: begin
                w.cond = C_DISP_MISS;
            end
            S_PUT_UPD: begin
                w.cond   = C_ALWAYS;
                w.target = S_EMIT_OK;
                w.wr_op  = WR_IDX;
            end
            S_DEL_PREP: begin
                w.rd_ahead = 1'b1;
            end
            S_DEL_SHIFT: begin
                w.cond     = C_LAST;
                w.target   = S_DEL_DONE;
                w.hold     = 1'b1;
                w.nt_only  = 1'b1;
                w.idx_op   = IDX_INC;
                w.rd_ahead = 1'b1;
                w.wr_op    = WR_SHIFT;
            end
            S_DEL_DONE: begin
                w.cond   = C_ALWAYS;
                w.target = S_EMIT_OK;
                w.cnt_op = CNT_DEC;
            end
            S_RDPOS: begin
                w.cond   = C_POS_BAD;
                w.target = S_EMIT_BEYOND;
                w.idx_op = IDX_POS;
            end
            S_APP: begin
                w.cond    = C_FULL;
                w.target  = S_EMIT_FULL;
                w.nt_only = 1'b1;
                w.wr_op   = WR_CNT;
                w.cnt_op  = CNT_INC;
            end
            S_EMIT_RD, S_EMIT_OK, S_EMIT_GETV, S_EMIT_NF, S_EMIT_FULL,
            S_EMIT_BEYOND: begin
                w.cond   = C_OUT_FREE;
                w.target = S_IDLE;
                w.hold   = 1'b1;
                w.emit   = 1'b1;
                unique case (step)
                    S_EMIT_RD: begin
                        w.kout_rd = 1'b1;
                        w.vout_rd = 1'b1;
                    end
                    S_EMIT_GETV:   w.vout_rd = 1'b1;
                    S_EMIT_NF:     w.status  = ST_NOT_FOUND;
                    S_EMIT_FULL:   w.status  = ST_FULL;
                    S_EMIT_BEYOND: w.status  = ST_BEYOND;
                    default:       w.status  = ST_OK;
                endcase
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic t_lkvt_step lkvt_dispatch(input t_lkvt_cond cond,
                                                 input logic [OP_W-1:0] op);
        t_lkvt_step s;
        s = S_EMIT_OK;
        unique case (cond)
            C_DISP_OP: begin
                unique case (op) inside
                    OP_PUT, OP_GET, OP_DELETE: s = S_SEARCH;
                    OP_APPEND:                 s = S_APP;
                    OP_READ:                   s = S_RDPOS;
                    default:                   s = S_EMIT_OK;
                endcase
            end
            C_DISP_HIT: begin
                unique case (op) inside
                    OP_PUT:    s = S_PUT_UPD;
                    OP_GET:    s = S_EMIT_GETV;
                    OP_DELETE: s = S_DEL_PREP;
                    default:   s = S_EMIT_OK;
                endcase
            end
            C_DISP_MISS: begin
                unique case (op) inside
                    OP_PUT:  s = S_APP;
                    default: s = S_EMIT_NF;
                endcase
            end
            default: s = S_EMIT_OK;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/lkvt_seq.sv -----
// ----------------------------------------------------------------------------
// lkvt_seq
// Microcode sequencer: step counter, control ROM and branch evaluation.
// ----------------------------------------------------------------------------
module lkvt_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lkvt_pkg::t_lkvt_flags i_flags,
    output lkvt_pkg::t_lkvt_act   o_act
);
    import lkvt_pkg::*;

    t_lkvt_step r_step;
    t_lkvt_step n_step;
    t_lkvt_ctrl ctrl;
    logic       taken;
    logic       is_disp;

    assign ctrl = lkvt_rom(r_step);

    always_comb begin
        is_disp = 1'b0;
        case (ctrl.cond)
            C_NEXT:      taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_ACCEPT:    taken = i_flags.in_valid;
            C_DISP_OP, C_DISP_HIT, C_DISP_MISS: begin
                taken   = 1'b1;
                is_disp = 1'b1;
            end
            C_DONE:      taken = i_flags.at_end | i_flags.match;
            C_END:       taken = i_flags.at_end;
            C_LAST:      taken = i_flags.last;
            C_FULL:      taken = i_flags.full;
            C_POS_BAD:   taken = i_flags.pos_bad;
            C_OUT_FREE:  taken = i_flags.out_free;
            default:     taken = 1'b0;
        endcase
    end

    always_comb begin
        if (taken) begin
            n_step = is_disp ? lkvt_dispatch(ctrl.cond, i_flags.op) : ctrl.target;
        end else if (ctrl.hold) begin
            n_step = r_step;
        end else begin
            n_step = t_lkvt_step'(r_step + 5'd1);
        end
    end

    always_comb begin
        o_act.ready    = ctrl.accept;
        o_act.load_in  = ctrl.accept & taken;
        o_act.idx_op   = (ctrl.nt_only && taken) ? IDX_KEEP : ctrl.idx_op;
        o_act.rd_ahead = ctrl.rd_ahead;
        o_act.wr_op    = (ctrl.nt_only && taken) ? WR_NONE  : ctrl.wr_op;
        o_act.cnt_op   = (ctrl.nt_only && taken) ? CNT_KEEP : ctrl.cnt_op;
        o_act.emit     = ctrl.emit & taken;
        o_act.status   = ctrl.status;
        o_act.kout_rd  = ctrl.kout_rd;
        o_act.vout_rd  = ctrl.vout_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- rtl/lkvt_dp.sv -----
// ----------------------------------------------------------------------------
// lkvt_dp
// Datapath: entry memory, index and fill count, compare, output register.
// ----------------------------------------------------------------------------
module lkvt_dp #(
    parameter int DEPTH       = lkvt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH   = lkvt_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lkvt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkvt_pkg::t_lkvt_act          i_act,
    input  logic                         i_in_valid,
    input  logic [lkvt_pkg::TDATA_W-1:0] i_in_data,
    input  logic                         i_out_ready,
    output lkvt_pkg::t_lkvt_flags        o_flags,
    output logic                         o_out_valid,
    output logic [lkvt_pkg::TDATA_W-1:0] o_out_data
);
    import lkvt_pkg::*;

    localparam int IW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int EW = KEY_WIDTH + VALUE_WIDTH;
    localparam int CW = (IW > POS_W) ? IW : POS_W;

    logic [OP_W-1:0]        r_op;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [POS_W-1:0]       r_pos;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          n_idx;
    logic [IW-1:0]          r_cnt;
    logic [IW-1:0]          n_cnt;
    logic [IW-1:0]          rd_next;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;
    logic [EW-1:0]          r_rd;
    logic [EW-1:0]          mem [DEPTH];
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic [KEY_W-1:0]       key_out;
    logic [VAL_W-1:0]       value_out;
    logic                   r_out_valid;
    logic [TDATA_W-1:0]     r_out_data;

    assign rd_key   = r_rd[EW-1:VALUE_WIDTH];
    assign rd_value = r_rd[VALUE_WIDTH-1:0];

    always_comb begin
        case (i_act.idx_op)
            IDX_KEEP: n_idx = r_idx;
            IDX_ZERO: n_idx = '0;
            IDX_INC:  n_idx = r_idx + IW'(1);
            IDX_POS:  n_idx = IW'(r_pos);
            default:  n_idx = r_idx;
        endcase
        case (i_act.cnt_op)
            CNT_INC: n_cnt = r_cnt + IW'(1);
            CNT_DEC: n_cnt = r_cnt - IW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    assign rd_next = i_act.rd_ahead ? (n_idx + IW'(1)) : n_idx;
    assign rd_addr = rd_next[AW-1:0];

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_idx[AW-1:0];
        wr_data = {r_key, r_value};
        case (i_act.wr_op)
            WR_NONE:  wr_en   = 1'b0;
            WR_IDX:   wr_addr = r_idx[AW-1:0];
            WR_CNT:   wr_addr = r_cnt[AW-1:0];
            WR_SHIFT: wr_data = r_rd;
            default:  wr_en   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_act.load_in) begin
            r_op    <= i_in_data[OP_W-1:0];
            r_key   <= KEY_WIDTH'(i_in_data[OP_W +: KEY_W]);
            r_value <= VALUE_WIDTH'(i_in_data[OP_W+KEY_W +: VAL_W]);
            r_pos   <= i_in_data[OP_W+KEY_W+VAL_W +: POS_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            r_idx <= n_idx;
            r_cnt <= n_cnt;
        end
    end

    assign key_out   = i_act.kout_rd ? KEY_W'(rd_key)   : '0;
    assign value_out = i_act.vout_rd ? VAL_W'(rd_value) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_act.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_act.emit) begin
            r_out_data <= {CNT_W'(r_cnt), value_out, key_out, i_act.status};
        end
    end

    always_comb begin
        o_flags.in_valid = i_in_valid;
        o_flags.out_free = ~r_out_valid | i_out_ready;
        o_flags.at_end   = (r_idx == r_cnt);
        o_flags.match    = (rd_key == r_key);
        o_flags.last     = ((r_idx + IW'(1)) == r_cnt);
        o_flags.full     = (r_cnt == IW'(DEPTH));
        o_flags.pos_bad  = (CW'(r_pos) >= CW'(r_cnt));
        o_flags.op       = r_op;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/linear_key_value_table_core.sv -----
// ----------------------------------------------------------------------------
// linear_key_value_table_core
// Insertion-ordered key-value table with linear search, run by microcode.
// ----------------------------------------------------------------------------
// Each input transaction is one request (put, append, get, delete, read at
// position) and yields exactly one output transaction with status, key,
// value and the fill count after the request. Requests are handled one at a
// time; the next request is taken while the previous result waits on the
// output. Entries sit in a single-port-write, single-port-read memory and the
// search walks it one entry per cycle; a delete adds a shift of one entry per
// cycle for the entries behind the hit. A result that cannot leave because the
// previous one is still held on the output adds its wait at the emit step. No
// clearing pass is needed after reset.
module linear_key_value_table_core #(
    parameter int DEPTH       = lkvt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH   = lkvt_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lkvt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // op[2:0], key_in[34:3], value_in[66:35], position[71:67]
    input  logic [lkvt_pkg::TDATA_W-1:0] i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // status[1:0], key_out[33:2], value_out[65:34], entry_count[71:66]
    output logic [lkvt_pkg::TDATA_W-1:0] o_m_axis_tdata
);
    import lkvt_pkg::*;

    t_lkvt_act   act;
    t_lkvt_flags flags;

    lkvt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_act   (act)
    );

    lkvt_dp #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_act       (act),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_flags     (flags),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

    assign o_s_axis_tready = act.ready & i_rst_n;

endmodule
